// ----- hdl/ffbp_pkg.sv -----
// Shared constants and control/status types for the first-fit bin packer.
package ffbp_pkg;

   localparam int MAX_BINS = 1024;
   localparam int IDX_W    = 10;     // bin index width
   localparam int COUNT_W  = 11;     // open bin count, 1..MAX_BINS
   localparam int SIZE_W   = 16;     // item size, bin fill, capacity
   localparam int SUM_W    = SIZE_W + 1;

   localparam logic [SIZE_W-1:0] CAPACITY_RESET = 16'd150;

   // controller -> datapath
   typedef struct packed {
      logic load;        // accept a request, restart the set if asked
      logic issue;       // read the next open bin
      logic commit_hit;  // place item into the bin just compared
      logic commit_new;  // open a new bin, or drop when full
   } ffbp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;         // bin read last cycle has room
      logic can_issue;   // unread open bins remain
      logic rd_pending;  // a read is in flight
   } ffbp_sts_type;

endpackage

// ----- hdl/ffbp_ctrl.sv -----
// Scan controller for the first-fit bin packer.
module ffbp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ffbp_pkg::ffbp_sts_type sts,
   output ffbp_pkg::ffbp_cmd_type cmd
);
   import ffbp_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.hit) begin
               cmd.commit_hit = 1'b1;
               state_in       = ST_IDLE;
            end else if (!sts.rd_pending && !sts.can_issue) begin
               // every open bin compared, none fit
               cmd.commit_new = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.issue = sts.can_issue;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_SCAN);

endmodule

// ----- hdl/ffbp_datapath.sv -----
// Bin fill memory, scan pointer, fit compare and result registers.
module ffbp_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  ffbp_pkg::ffbp_cmd_type       cmd,
   output ffbp_pkg::ffbp_sts_type       sts,
   input  logic [ffbp_pkg::SIZE_W-1:0]  req_item_size,
   input  logic                         req_first_item,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ffbp_pkg::SIZE_W-1:0]  csr_data,
   output logic                         rsp_valid,
   output logic [ffbp_pkg::IDX_W-1:0]   rsp_bin_index,
   output logic [ffbp_pkg::COUNT_W-1:0] rsp_bins_used,
   output logic                         rsp_oversize,
   output logic                         rsp_no_room
);
   import ffbp_pkg::*;

   logic [SIZE_W-1:0]  bin_fill_ff [MAX_BINS];
   logic [SIZE_W-1:0]  rd_data_ff;

   logic [SIZE_W-1:0]  capacity_ff, capacity_in;
   logic [COUNT_W-1:0] open_count_ff, open_count_in;
   logic               zero_valid_ff, zero_valid_in;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [COUNT_W-1:0] scan_ff;
   logic [SIZE_W-1:0]  size_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   bin_index_ff, bin_index_in;
   logic [COUNT_W-1:0] bins_used_ff, bins_used_in;
   logic               oversize_ff, oversize_in;
   logic               no_room_ff, no_room_in;

   logic [SIZE_W-1:0]  fill;
   logic [SUM_W-1:0]   sum;
   logic               fits;
   logic               room;
   logic               mem_we;
   logic [IDX_W-1:0]   wr_addr;
   logic [SIZE_W-1:0]  wr_data;

   // entry zero reads as empty until written after reset or a restart
   assign fill = (rd_idx_ff == '0 && !zero_valid_ff) ? '0 : rd_data_ff;
   assign sum  = {1'b0, fill} + {1'b0, size_ff};
   assign fits = (sum <= {1'b0, capacity_ff});
   assign room = (open_count_ff < COUNT_W'(MAX_BINS));

   assign sts.hit        = rd_vld_ff && fits;
   assign sts.can_issue  = (scan_ff < open_count_ff);
   assign sts.rd_pending = rd_vld_ff;

   assign mem_we  = cmd.commit_hit || (cmd.commit_new && room);
   assign wr_addr = cmd.commit_hit ? rd_idx_ff : open_count_ff[IDX_W-1:0];
   assign wr_data = cmd.commit_hit ? sum[SIZE_W-1:0] : size_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_fill_ff[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rd_data_ff <= bin_fill_ff[scan_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      capacity_in   = csr_valid ? csr_data : capacity_ff;
      open_count_in = open_count_ff;
      zero_valid_in = zero_valid_ff;
      if (cmd.load && req_first_item) begin
         open_count_in = COUNT_W'(1);
         zero_valid_in = 1'b0;
      end
      if (cmd.commit_new && room) begin
         open_count_in = open_count_ff + COUNT_W'(1);
      end
      if (mem_we && wr_addr == '0) begin
         zero_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = cmd.commit_hit || cmd.commit_new;
      bin_index_in = bin_index_ff;
      bins_used_in = bins_used_ff;
      oversize_in  = oversize_ff;
      no_room_in   = no_room_ff;
      if (cmd.commit_hit) begin
         bin_index_in = rd_idx_ff;
         bins_used_in = open_count_ff;
         oversize_in  = 1'b0;
         no_room_in   = 1'b0;
      end else if (cmd.commit_new) begin
         if (room) begin
            bin_index_in = open_count_ff[IDX_W-1:0];
            bins_used_in = open_count_ff + COUNT_W'(1);
            oversize_in  = (size_ff > capacity_ff);
            no_room_in   = 1'b0;
         end else begin
            bin_index_in = '0;
            bins_used_in = open_count_ff;
            oversize_in  = 1'b0;
            no_room_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         open_count_ff <= COUNT_W'(1);
         zero_valid_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         open_count_ff <= open_count_in;
         zero_valid_ff <= zero_valid_in;
         rd_vld_ff     <= cmd.issue;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         size_ff <= req_item_size;
         scan_ff <= '0;
      end else if (cmd.issue) begin
         scan_ff <= scan_ff + COUNT_W'(1);
      end
      if (cmd.issue) begin
         rd_idx_ff <= scan_ff[IDX_W-1:0];
      end
      bin_index_ff <= bin_index_in;
      bins_used_ff <= bins_used_in;
      oversize_ff  <= oversize_in;
      no_room_ff   <= no_room_in;
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = bin_index_ff;
   assign rsp_bins_used = bins_used_ff;
   assign rsp_oversize  = oversize_ff;
   assign rsp_no_room   = no_room_ff;

endmodule

// ----- hdl/first_fit_bin_packer_unit.sv -----
// Top level of the first-fit bin packer: controller, datapath and checks.
//
// Usage:
//  - Request: drive req_item_size and req_first_item with start high; the
//    request is taken at a clock edge where start is high and busy is low.
//    req_first_item restarts the set (one empty bin open) before placing.
//  - Result: one per request, shown for exactly one cycle with rsp_valid
//    high. The receiver cannot stall; rsp_* hold their value otherwise.
//  - Config: csr_data is the bin capacity, written when csr_valid and
//    csr_ready are high (csr_ready is always high). Write only while idle.
//  - Scan: open bins are read from a single-port fill memory, one bin
//    per cycle, with a registered read. The scan stops at the first bin
//    with room; an item that fits none opens a new bin, or is dropped when
//    all bins are open, only after every open bin has been compared.
//    busy falls in the cycle rsp_valid rises, so the next request may be
//    taken in that same cycle.
//  - Reset: synchronous, active high. Capacity returns to 150 and one
//    empty bin is open. No memory clearing pass is needed: bin 0 reads as
//    empty until written, the other bins are written when opened.
module first_fit_bin_packer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ffbp_pkg::SIZE_W-1:0]  req_item_size,
   input  logic                         req_first_item,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ffbp_pkg::SIZE_W-1:0]  csr_data,
   output logic                         rsp_valid,
   output logic [ffbp_pkg::IDX_W-1:0]   rsp_bin_index,
   output logic [ffbp_pkg::COUNT_W-1:0] rsp_bins_used,
   output logic                         rsp_oversize,
   output logic                         rsp_no_room
);
   import ffbp_pkg::*;

   ffbp_cmd_type cmd;   // scan commands from the controller
   ffbp_sts_type sts;   // compare/pointer status back from the datapath

   // state machine: idle / scanning open bins
   ffbp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // fill memory, read pipeline, fit compare, result registers
   ffbp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_item_size  (req_item_size),
      .req_first_item (req_first_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_bins_used  (rsp_bins_used),
      .rsp_oversize   (rsp_oversize),
      .rsp_no_room    (rsp_no_room)
   );

   // a taken request always leaves the block busy for the scan
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // a scan reads at least one bin before it commits, so results never come back to back
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a placed item sits in a bin that is open
   a_index_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_no_room) |-> (COUNT_W'(rsp_bin_index) < rsp_bins_used))
      else $error("result bin index beyond open bins");

   // bin count stays in range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bins_used != '0 && rsp_bins_used <= COUNT_W'(MAX_BINS)))
      else $error("bins used out of range");

   // a dropped item is only reported when every bin is open
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_room) |-> (rsp_bins_used == COUNT_W'(MAX_BINS)))
      else $error("item dropped while bins remain");

endmodule

// ----- dv/ffbp_placement_checker.sv -----
// Scoreboard for the first-fit bin packer: predicts each placement and checks every response.
module ffbp_placement_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [ffbp_pkg::SIZE_W-1:0]  req_item_size,
   input  logic                         req_first_item,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [ffbp_pkg::SIZE_W-1:0]  csr_data,
   input  logic                         rsp_valid,
   input  logic [ffbp_pkg::IDX_W-1:0]   rsp_bin_index,
   input  logic [ffbp_pkg::COUNT_W-1:0] rsp_bins_used,
   input  logic                         rsp_oversize,
   input  logic                         rsp_no_room,
   output int                           fail_count,
   output int                           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ffbp_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]   bin_index;
      logic [COUNT_W-1:0] bins_used;
      logic               oversize;
      logic               no_room;
   } placement_type;

   localparam int REPORT_LIMIT = 10;

   logic [SIZE_W-1:0] model_capacity;
   logic [SIZE_W-1:0] fill_level [MAX_BINS];
   int unsigned       open_bins;
   placement_type     expected_placements [$];
   placement_type     observed;
   placement_type     predicted;
   int                mismatches;

   // first fit over the open bins; a new bin is opened only when none takes the item
   function automatic placement_type place_item(input logic [SIZE_W-1:0] size,
                                                input logic restart);
      placement_type p;
      logic          placed;
      p      = '0;
      placed = 1'b0;
      if (restart) begin
         fill_level[0] = '0;
         open_bins     = 1;
      end
      for (int j = 0; j < open_bins && !placed; j++) begin
         if ({1'b0, fill_level[j]} + {1'b0, size} <= {1'b0, model_capacity}) begin
            fill_level[j] = fill_level[j] + size;
            p.bin_index   = IDX_W'(j);
            placed        = 1'b1;
         end
      end
      if (!placed) begin
         if (open_bins < MAX_BINS) begin
            fill_level[open_bins] = size;
            p.bin_index           = IDX_W'(open_bins);
            p.oversize            = (size > model_capacity);
            open_bins++;
         end else begin
            p.no_room = 1'b1;   // dropped, state untouched
         end
      end
      p.bins_used = COUNT_W'(open_bins);
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         model_capacity = CAPACITY_RESET;
         fill_level[0]  = '0;
         open_bins      = 1;
         expected_placements.delete();
         mismatches     = 0;
      end else begin
         // response first: it belongs to a request taken at an earlier edge
         if (rsp_valid) begin
            observed = {rsp_bin_index, rsp_bins_used, rsp_oversize, rsp_no_room};
            if (expected_placements.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: response with no request waiting: ", $time,
                           "bin %0d used %0d oversize %0b no_room %0b",
                           observed.bin_index, observed.bins_used,
                           observed.oversize, observed.no_room);
            end else begin
               predicted = expected_placements.pop_front();
               if (observed.bin_index !== predicted.bin_index ||
                   observed.bins_used !== predicted.bins_used ||
                   observed.oversize  !== predicted.oversize  ||
                   observed.no_room   !== predicted.no_room) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: mismatch: ", $time,
                              "expected bin %0d used %0d oversize %0b no_room %0b, ",
                              predicted.bin_index, predicted.bins_used,
                              predicted.oversize, predicted.no_room,
                              "got bin %0d used %0d oversize %0b no_room %0b",
                              observed.bin_index, observed.bins_used,
                              observed.oversize, observed.no_room);
               end
            end
         end
         if (csr_valid && csr_ready)
            model_capacity = csr_data;
         if (start && !busy)
            expected_placements.insert(expected_placements.size(),
                                       place_item(req_item_size, req_first_item));
      end
      fail_count <= mismatches;
      pending    <= expected_placements.size();
   end

endmodule

// ----- dv/tb_first_fit_bin_packer_unit.sv -----
// Testbench top for the first-fit bin packer: stimulus, watchdog and verdict.
module tb_first_fit_bin_packer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ffbp_pkg::*;

   // Longest correct wait is a full scan of 1024 bins plus the
   // longest sender gap; the limit takes that several times over.
   localparam int WATCHDOG_LIMIT = 8000;
   // quiet cycles after the last response, about one worst-case scan
   localparam int SETTLE_CYCLES  = 1100;
   localparam int RANDOM_ITEMS   = 558;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [SIZE_W-1:0]    req_item_size;
   logic                 req_first_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [SIZE_W-1:0]    csr_data;
   logic                 rsp_valid;
   logic [IDX_W-1:0]     rsp_bin_index;
   logic [COUNT_W-1:0]   rsp_bins_used;
   logic                 rsp_oversize;
   logic                 rsp_no_room;

   int                   fail_count;
   int                   pending;
   int                   idle_cycles;
   logic                 gaps_on;
   logic [SIZE_W-1:0]    capacity_now;   // what the stimulus last wrote, for size shaping

   first_fit_bin_packer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item_size  (req_item_size),
      .req_first_item (req_first_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_bins_used  (rsp_bins_used),
      .rsp_oversize   (rsp_oversize),
      .rsp_no_room    (rsp_no_room)
   );

   ffbp_placement_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item_size  (req_item_size),
      .req_first_item (req_first_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_bins_used  (rsp_bins_used),
      .rsp_oversize   (rsp_oversize),
      .rsp_no_room    (rsp_no_room),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any accepted request, response or capacity write counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_first_fit_bin_packer_unit: FAIL");
            $finish;
         end
      end
   end

   // Present one request and hold it until the edge where busy is low.
   // Returns at that edge, so the caller may present the next one at once.
   task automatic send_item(input logic [SIZE_W-1:0] size, input logic first);
      start          <= 1'b1;
      req_item_size  <= size;
      req_first_item <= first;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for the requested gap; the payload is randomized meanwhile to show it is ignored.
   task automatic idle_for(input int n);
      if (n > 0) begin
         start          <= 1'b0;
         req_item_size  <= SIZE_W'($urandom);
         req_first_item <= 1'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   // Hold off until every request has been answered. The checker's count
   // is registered, so the task waits for an edge before it looks.
   task automatic wait_all_placed();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Capacity changes only with nothing in flight.
   task automatic write_capacity(input logic [SIZE_W-1:0] value);
      wait_all_placed();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      capacity_now = value;
   endtask

   // mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SIZE_W-1:0] pick_capacity();
      case ($urandom_range(0, 9))
         0:       return 16'd150;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3:       return 16'd0;               // out of spec, taken literally
         4, 5:    return SIZE_W'($urandom_range(1, 65535));
         default: return SIZE_W'($urandom_range(2, 400));
      endcase
   endfunction

   // Sizes are shaped against the capacity so that bins actually pack; the
   // rest is oversize items and raw 16-bit noise.
   function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] cap);
      int r;
      int c;
      r = $urandom_range(0, 99);
      c = cap;
      if (r < 8)  return '0;
      if (r < 55) return SIZE_W'($urandom_range(0, c));
      if (r < 72) return SIZE_W'($urandom_range(c / 4, c / 2));
      if (r < 82) return cap;                  // exact fit of an empty bin
      if (r < 92) return (c == 65535) ? cap : SIZE_W'($urandom_range(c + 1, 65535));
      return SIZE_W'($urandom);
   endfunction

   initial begin
      int items_sent;
      int set_len;
      logic first;

      reset          = 1'b1;
      start          = 1'b0;
      req_item_size  = '0;
      req_first_item = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      gaps_on        = 1'b0;
      capacity_now   = CAPACITY_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: reset capacity of 150 ----
      send_item(16'd100, 1'b0);     // first item with no restart lands in the reset bin
      send_item(16'd50, 1'b0);      // fills bin 0 exactly
      send_item(16'd0, 1'b0);       // zero still fits a full bin
      send_item(16'd151, 1'b0);     // just over capacity: new bin, oversize
      send_item(16'hFFFF, 1'b0);    // largest size, oversize
      send_item(16'd0, 1'b1);       // restart with a zero item
      send_item(16'd150, 1'b0);

      // lower the capacity under bin 0's fill, then try oversize, zero-size and exact-fit items
      write_capacity(16'd100);
      send_item(16'd200, 1'b0);     // oversize bin
      send_item(16'd0, 1'b0);       // skips both overfull bins, opens an empty one
      send_item(16'd100, 1'b0);

      // widest capacity: sums reach 17 bits
      write_capacity(16'hFFFF);
      send_item(16'hFFFF, 1'b1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'hFFFE, 1'b0);

      // zero capacity: only zero-size items fit the empty bin
      write_capacity(16'd0);
      send_item(16'd0, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);

      // unit capacity
      write_capacity(16'd1);
      send_item(16'd1, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd2, 1'b0);

      // ---- random sets under a series of capacities ----
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         write_capacity(pick_capacity());
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 6)) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            for (int i = 0; i < set_len && items_sent < RANDOM_ITEMS; i++) begin
               // sets mostly open with a restart; stray restarts inside are noise
               first = (i == 0) ? ($urandom_range(0, 7) != 0)
                                : ($urandom_range(0, 24) == 0);
               send_item(pick_size(capacity_now), first);
               items_sent++;
               idle_for(pick_gap());
            end
            if ($urandom_range(0, 4) == 0)
               wait_all_placed();
         end
      end

      wait_all_placed();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_first_fit_bin_packer_unit: PASS");
      else
         $display("tb_first_fit_bin_packer_unit: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/ffbp_pkg.sv
hdl/ffbp_ctrl.sv
hdl/ffbp_datapath.sv
hdl/first_fit_bin_packer_unit.sv
dv/ffbp_placement_checker.sv
dv/tb_first_fit_bin_packer_unit.sv
